/* rtl/core/state_transition_novelty_fold_unit_macros.svh */
// assertion macros for the novelty fold unit checker
// depends on nothing; included by the checker file only
`ifndef STATE_TRANSITION_NOVELTY_FOLD_UNIT_MACROS_SVH
`define STATE_TRANSITION_NOVELTY_FOLD_UNIT_MACROS_SVH

// property checked outside reset
`define STNF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define STNF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/stnf_pkg.sv */
// shared types and constants of the novelty fold unit
// no dependencies
`timescale 1ns / 1ps

package stnf_pkg;

  localparam int OP_W       = 2;
  localparam int SLOT_W     = 16;
  localparam int HIT_W      = 8;
  localparam int COUNT_W    = 32;
  localparam int SHIFT_W    = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [OP_W-1:0] OP_TOUCH = 2'd0;
  localparam logic [OP_W-1:0] OP_WALK  = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_COARSE_SHIFT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_FINDS  = 1'd1;

  localparam logic [HIT_W-1:0] UNSEEN = 8'hff;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic modify;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic needs_rmw;
    logic is_end;
    logic out_blocked;
  } ctrl_status_t;

endpackage

/* rtl/core/stnf_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module stnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/stnf_ctrl.sv */
// controller: clearing pass, item acceptance and read-modify-write sequencing
// depends on stnf_pkg
`timescale 1ns / 1ps

module stnf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  stnf_pkg::ctrl_status_t sts,
  output stnf_pkg::ctrl_cmd_t   cmd
);

  import stnf_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_MODIFY = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // an end item waits while the previous result is still held
  assign in_stall = (state != ST_IDLE) || (sts.out_blocked && sts.is_end);
  assign accept   = in_valid && !in_stall;

  assign cmd.clear_step = (state == ST_CLEAR);
  assign cmd.accept     = accept;
  assign cmd.modify     = (state == ST_MODIFY);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && sts.needs_rmw) begin
          state_next = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/stnf_datapath.sv */
// datapath: config registers, map ram, flag, find counter, result register
// depends on stnf_pkg and stnf_ram
`timescale 1ns / 1ps

module stnf_datapath #(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [stnf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stnf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [stnf_pkg::OP_W-1:0]       operation,
  input  logic [stnf_pkg::SLOT_W-1:0]     slot_index,
  input  logic [stnf_pkg::HIT_W-1:0]      hit_value,
  input  logic                            out_stall,
  input  stnf_pkg::ctrl_cmd_t             cmd,
  output stnf_pkg::ctrl_status_t          sts,
  output logic                            out_valid,
  output logic                            execution_new,
  output logic [stnf_pkg::COUNT_W-1:0]    finds_total
);

  import stnf_pkg::*;

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int CW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_ENTRIES - 1);

  logic [SHIFT_W-1:0] coarse_shift;
  logic               count_finds;

  logic [SLOT_W-1:0]  folded;
  logic [CW-1:0]      folded_ext;
  logic               in_range;
  logic               is_touch;
  logic               is_walk;
  logic               is_end;

  logic [AW-1:0]      addr_r;
  logic [HIT_W-1:0]   hit_r;
  logic               fold_r;

  logic [AW-1:0]      clear_addr;
  logic [HIT_W-1:0]   rdata;
  logic               unseen;
  logic [HIT_W-1:0]   mod_data;
  logic               find;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [HIT_W-1:0]   ram_wdata;

  logic               new_flag;
  logic [COUNT_W-1:0] find_counter;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coarse_shift <= '0;
      count_finds  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COARSE_SHIFT: coarse_shift <= cfg_data[SHIFT_W-1:0];
        REG_COUNT_FINDS:  count_finds  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a walk with zero shift uses the slot itself, so one shift serves both
  assign folded     = slot_index >> coarse_shift;
  assign folded_ext = {{(CW-SLOT_W){1'b0}}, folded};
  assign in_range   = folded_ext < CW'(MAP_ENTRIES);
  assign is_touch   = (operation == OP_TOUCH);
  assign is_walk    = (operation == OP_WALK);
  assign is_end     = (operation == OP_END);

  assign sts.needs_rmw   = in_range && (is_touch || (is_walk && (hit_value != '0)));
  assign sts.is_end      = is_end;
  assign sts.clear_done  = (clear_addr == LAST_ADDR);
  assign sts.out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r <= folded_ext[AW-1:0];
      hit_r  <= hit_value;
      fold_r <= is_touch || (coarse_shift != '0);
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign unseen   = (rdata == UNSEEN);
  assign mod_data = fold_r ? (unseen ? '0 : rdata) : (rdata & ~hit_r);
  assign find     = cmd.modify && unseen;

  assign ram_we    = cmd.clear_step || cmd.modify;
  assign ram_waddr = cmd.clear_step ? clear_addr : addr_r;
  assign ram_wdata = cmd.clear_step ? UNSEEN : mod_data;

  stnf_ram #(
    .WIDTH (HIT_W),
    .DEPTH (MAP_ENTRIES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (folded_ext[AW-1:0]),
    .rdata (rdata)
  );

  // per-run new flag and saturating counter
  always_ff @(posedge clk) begin
    if (rst) begin
      new_flag     <= 1'b0;
      find_counter <= '0;
    end else begin
      if (find) begin
        new_flag <= 1'b1;
        if (count_finds && (find_counter != '1)) begin
          find_counter <= find_counter + 1'b1;
        end
      end else if (cmd.accept && is_end) begin
        new_flag <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept && is_end) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_end) begin
      execution_new <= new_flag;
      finds_total   <= find_counter;
    end
  end

endmodule

/* rtl/core/state_transition_novelty_fold_unit.sv */
// top level of the state transition novelty fold unit
// depends on stnf_pkg, stnf_ctrl, stnf_datapath (and stnf_ram below it)
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall with operation, slot_index, hit_value
//     touch items (slot index) and walk items (slot, hit byte) update the
//     never-seen map; an end item closes one execution
//   output channel: out_valid / out_stall with execution_new, finds_total,
//     one result per end item, nothing for any other item
//   config: cfg_we, cfg_index, cfg_data write coarse_shift or count_finds,
//     only while the block is idle, a rule the block does not enforce
// reset
//   rst clears the controller, flag, counter and config; then a clearing
//   pass writes 0xff into every map entry, with in_stall high the whole
//   time (config writes still land)
// timing
//   an item that reads the map (in range, touch or nonzero walk) holds
//   the input: the registered map read lands in the cycle after the accept,
//   then modify and write-back run in that cycle
//   every other item (end, ignored, out of range) has no modify step
//   an end item's result shows on the output the cycle after it is accepted
// stall
//   the result sits in an output register; items keep flowing while it
//   waits, only a further end item is held until the result is taken
module state_transition_novelty_fold_unit #(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  // config write port
  input  logic                             cfg_we,
  input  logic [stnf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stnf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [stnf_pkg::OP_W-1:0]        operation,
  input  logic [stnf_pkg::SLOT_W-1:0]      slot_index,
  input  logic [stnf_pkg::HIT_W-1:0]       hit_value,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             execution_new,
  output logic [stnf_pkg::COUNT_W-1:0]     finds_total
);

  import stnf_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t sts;

  // sequencing: clearing pass, then accept / modify
  stnf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // map ram, fold logic, counter and result register
  stnf_datapath #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .slot_index    (slot_index),
    .hit_value     (hit_value),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .execution_new (execution_new),
    .finds_total   (finds_total)
  );

endmodule

/* rtl/core/stnf_checker.sv */
// port-level checker for the novelty fold unit, bound to the top level
// depends on stnf_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "state_transition_novelty_fold_unit_macros.svh"

module stnf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [stnf_pkg::OP_W-1:0]        operation,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             execution_new,
  input logic [stnf_pkg::COUNT_W-1:0]     finds_total
);

  import stnf_pkg::*;

  logic end_accept;

  assign end_accept = in_valid && !in_stall && (operation == OP_END);

  // the clearing pass follows reset, so no item gets in and no result is shown
  `STNF_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (in_stall && !out_valid), "not quiet after reset")

  // a result appears only right after an end item was taken
  `STNF_ASSERT(a_result_from_end, clk, rst, $rose(out_valid) |-> $past(end_accept), "result without end item")

  // a taken result without a new end item leaves the output empty
  `STNF_ASSERT(a_no_repeat, clk, rst, (out_valid && !out_stall && !end_accept) |=> !out_valid, "result repeated")

  // a held result keeps its payload
  `STNF_ASSERT(a_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(finds_total) && $stable(execution_new)), "stalled result changed")

endmodule

bind state_transition_novelty_fold_unit stnf_checker u_stnf_checker (.*);

/* tb/sv/tb_top.sv */
// self-checking testbench for the state transition novelty fold unit
// depends on stnf_pkg and state_transition_novelty_fold_unit (rtl/core)
`timescale 1ns / 1ps

module tb_top;
  import stnf_pkg::*;

  localparam int MAP_DEPTH = 65536;
  // extra cycles after the last result so a trailing map update has landed
  localparam int SETTLE_CYCLES = 6;
  // length of the long receiver hold-off that backs the block up
  localparam int HOLD_CYCLES = 500;
  // the whole run, clearing pass included, stays far below this limit
  localparam longint RUN_LIMIT_NS = 64'd10_000_000;

  // operation code the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [HIT_W-1:0]  hit;
  } novelty_item_t;

  typedef struct packed {
    logic               is_new;
    logic [COUNT_W-1:0] finds;
  } novelty_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   operation = '0;
  logic [SLOT_W-1:0] slot_index = '0;
  logic [HIT_W-1:0]  hit_value = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               execution_new;
  logic [COUNT_W-1:0] finds_total;

  // items waiting to be offered, and end-of-execution reports still owed
  novelty_item_t   pending_items[$];
  novelty_report_t expected_reports[$];
  novelty_item_t   offered_item;

  // shadow copy of the block state and its configuration
  logic [HIT_W-1:0]   unseen_bytes [MAP_DEPTH];
  logic               run_found;
  logic [COUNT_W-1:0] finds_count;
  logic [SHIFT_W-1:0] shift_copy;
  logic               count_copy;

  // idling knobs, percent of cycles; changed only at the falling edge
  int send_idle_pct = 0;
  int stall_pct = 0;

  // long hold-off request handshake between the sequence and its counter
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  int errors_seen = 0;

  state_transition_novelty_fold_unit #(
    .MAP_ENTRIES(MAP_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .slot_index   (slot_index),
    .hit_value    (hit_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .execution_new(execution_new),
    .finds_total  (finds_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // a newly seen entry sets the per-execution flag; the counter saturates
  task automatic note_new_entry();
    run_found = 1'b1;
    if (count_copy && finds_count != '1) begin
      finds_count = finds_count + 1'b1;
    end
  endtask

  // coarse path: whole entry goes from unseen to cleared
  task automatic fold_slot(logic [SLOT_W-1:0] slot);
    int unsigned entry;
    entry = 32'(slot) >> shift_copy;
    if (entry >= MAP_DEPTH) begin
      return;
    end
    if (unseen_bytes[entry] == UNSEEN) begin
      unseen_bytes[entry] = '0;
      note_new_entry();
    end
  endtask

  task automatic fold_item(novelty_item_t it);
    case (it.op)
      OP_TOUCH: begin
        fold_slot(it.slot);
      end
      OP_WALK: begin
        // zero hit byte: nothing at all
        if (it.hit != '0) begin
          if (shift_copy != '0) begin
            fold_slot(it.slot);
          end else if (32'(it.slot) < MAP_DEPTH) begin
            // exact path: new only if untouched, then clear just the hit bits
            if (unseen_bytes[it.slot] == UNSEEN) begin
              note_new_entry();
            end
            unseen_bytes[it.slot] = unseen_bytes[it.slot] & ~it.hit;
          end
        end
      end
      OP_END: begin
        expected_reports.push_back('{is_new: run_found, finds: finds_count});
        run_found = 1'b0;
      end
      default: begin
        // unused code, ignored by the block
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // input driver: holds a stalled item, otherwise maybe idles a cycle
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_item(offered_item);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_item = pending_items.pop_front();
          in_valid   <= 1'b1;
          operation  <= offered_item.op;
          slot_index <= offered_item.slot;
          hit_value  <= offered_item.hit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor and receiver stall
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    novelty_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result item: execution_new %0d finds_total %0d",
                   $time, execution_new, finds_total);
          errors_seen++;
        end else begin
          want = expected_reports.pop_front();
          if (execution_new !== want.is_new) begin
            $display("%0t: execution_new mismatch: expected %0d actual %0d",
                     $time, want.is_new, execution_new);
            errors_seen++;
          end
          if (finds_total !== want.finds) begin
            $display("%0t: finds_total mismatch: expected %0d actual %0d",
                     $time, want.finds, finds_total);
            errors_seen++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // long hold-off counter, started by the sequence below
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  task automatic push_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                           logic [HIT_W-1:0] hit);
    pending_items.push_back('{op: op, slot: slot, hit: hit});
  endtask

  // register write; only called with the block idle, so the shadow can move now
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COARSE_SHIFT) begin
      shift_copy = val[SHIFT_W-1:0];
    end else begin
      count_copy = val[0];
    end
  endtask

  // every item taken, every report seen, then let a last map update finish
  task automatic wait_drain();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one execution: touches and walks mostly inside a small pool so entries
  // get revisited, some full-range slots, a little noise, then usually an end
  task automatic push_execution(logic [SLOT_W-1:0] pool_base);
    int n;
    int roll;
    logic [SLOT_W-1:0] span;
    novelty_item_t it;
    n = $urandom_range(0, 16);
    span = ($urandom_range(0, 1) != 0) ? 16'h003f : 16'h03ff;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      it.op = (roll < 55) ? OP_TOUCH : (roll < 95) ? OP_WALK : OP_UNUSED;
      if ($urandom_range(0, 99) < 70) begin
        it.slot = pool_base + (SLOT_W'($urandom) & span);
      end else begin
        it.slot = SLOT_W'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        it.hit = '0;
      end else if (roll < 40) begin
        it.hit = HIT_W'(1) << $urandom_range(0, HIT_W - 1);
      end else begin
        it.hit = HIT_W'($urandom);
      end
      pending_items.push_back(it);
    end
    // an execution now and then runs into the next one without its marker
    if ($urandom_range(0, 99) < 94) begin
      push_item(OP_END, SLOT_W'($urandom), HIT_W'($urandom));
    end
  endtask

  // one random phase: settings, idling, a batch of executions, then drain
  task automatic run_phase(int send_pct, int recv_pct, int shift, int count,
                           int target, bit long_hold);
    logic [SLOT_W-1:0] pool_base;
    write_reg(REG_COARSE_SHIFT, CFG_DATA_W'(shift));
    write_reg(REG_COUNT_FINDS, CFG_DATA_W'(count));
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    pool_base = SLOT_W'($urandom);
    // pops only happen at the rising edge, so the queue size counts pushes
    while (pending_items.size() < target) begin
      push_execution(pool_base);
    end
    if (long_hold) begin
      hold_req++;
    end
    wait_drain();
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    for (int i = 0; i < MAP_DEPTH; i++) begin
      unseen_bytes[i] = UNSEEN;
    end
    run_found   = 1'b0;
    finds_count = '0;
    shift_copy  = '0;
    count_copy  = 1'b1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings; the driver waits out the clearing pass
    @(negedge clk);
    push_item(OP_END, 16'h0000, 8'h00);      // nothing found yet
    push_item(OP_TOUCH, 16'h0000, 8'h00);    // lowest slot
    push_item(OP_TOUCH, 16'hffff, 8'hff);    // highest slot
    push_item(OP_END, 16'hffff, 8'hff);
    push_item(OP_WALK, 16'h1234, 8'h00);     // zero hit byte does nothing
    push_item(OP_WALK, 16'h1234, 8'h01);     // new, entry keeps other bits
    push_item(OP_WALK, 16'h1234, 8'h80);     // partly cleared, not new
    push_item(OP_WALK, 16'h1234, 8'hff);
    push_item(OP_END, 16'h0000, 8'h00);
    push_item(OP_UNUSED, 16'h4321, 8'hff);   // unused code must not touch the map
    push_item(OP_TOUCH, 16'h4321, 8'h00);    // so this one is still new
    push_item(OP_END, 16'h0000, 8'h00);
    push_item(OP_END, 16'h0000, 8'h00);      // back-to-back markers, flag cleared
    push_item(OP_WALK, 16'h00ff, 8'hff);     // full hit byte empties the entry
    push_item(OP_TOUCH, 16'h00ff, 8'h00);    // already seen
    push_item(OP_END, 16'h0000, 8'h00);
    wait_drain();

    // widest fold with counting off: flag still set, counter frozen
    write_reg(REG_COARSE_SHIFT, 4'd15);
    write_reg(REG_COUNT_FINDS, 4'd0);
    @(negedge clk);
    push_item(OP_TOUCH, 16'h8000, 8'h00);
    push_item(OP_TOUCH, 16'h7fff, 8'h00);
    push_item(OP_WALK, 16'hffff, 8'h55);
    push_item(OP_WALK, 16'h0001, 8'h00);
    push_item(OP_END, 16'h0000, 8'h00);
    wait_drain();
    write_reg(REG_COUNT_FINDS, 4'd1);
    @(negedge clk);
    push_item(OP_WALK, 16'h0000, 8'haa);
    push_item(OP_END, 16'h0000, 8'h00);
    wait_drain();

    // random phases over idling patterns and register settings
    run_phase(0, 0, 0, 1, 220, 1'b0);
    run_phase(81, 0, 4, 1, 220, 1'b0);
    run_phase(0, 81, $urandom_range(1, 14), 0, 220, 1'b0);
    run_phase(10, 10, 15, 1, 220, 1'b0);
    // receiver holds off while the sender keeps going, so the block backs up
    run_phase(0, 0, 0, 1, 220, 1'b1);
    run_phase(10, 10, $urandom_range(0, 15), $urandom_range(0, 1), 220, 1'b0);
    run_phase(0, 0, 8, 1, 220, 1'b0);

    if (errors_seen == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* state_transition_novelty_fold_unit.f */
+incdir+rtl/core
rtl/core/stnf_pkg.sv
rtl/core/stnf_ram.sv
rtl/core/stnf_ctrl.sv
rtl/core/stnf_datapath.sv
rtl/core/state_transition_novelty_fold_unit.sv
rtl/core/stnf_checker.sv
tb/sv/tb_top.sv
